// ===== src/erm_pkg.sv =====
package erm_pkg;

    localparam int TRIG_STAGES   = 14;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STAGES = (TRIG_STAGES > ATAN_LEN) ? ATAN_LEN : TRIG_STAGES;

    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 16;
    localparam int RED_W   = 35;   // scaled angle before reduction
    localparam int CW      = 33;   // CORDIC x, y, z
    localparam int TRIG_W  = 22;   // Q20 sine and cosine
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int SUM_W   = 64;

    // reduction, fold, rounding and the four matrix stages
    localparam int LATENCY = CORDIC_STAGES + 7;

    localparam logic signed [RED_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0]    GAIN_Q30    = 33'sd652032874;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] t;
        case (idx)
            0:       t = 33'sh03243F6A8;
            1:       t = 33'sh01DAC6705;
            2:       t = 33'sh00FADBAFC;
            3:       t = 33'sh007F56EA6;
            4:       t = 33'sh003FEAB76;
            5:       t = 33'sh001FFD55B;
            6:       t = 33'sh000FFFAAA;
            7:       t = 33'sh0007FFF55;
            8:       t = 33'sh0003FFFEA;
            9:       t = 33'sh0001FFFFD;
            10:      t = 33'sh0000FFFFF;
            11:      t = 33'sh00007FFFF;
            12:      t = 33'sh00003FFFF;
            13:      t = 33'sh00001FFFF;
            14:      t = 33'sh00000FFFF;
            15:      t = 33'sh000007FFF;
            16:      t = 33'sh000003FFF;
            17:      t = 33'sh000001FFF;
            18:      t = 33'sh000000FFF;
            19:      t = 33'sh0000007FF;
            20:      t = 33'sh0000003FF;
            21:      t = 33'sh0000001FF;
            22:      t = 33'sh0000000FF;
            23:      t = 33'sh00000007F;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Q60 to Q2.14: round half up, then clamp
    function automatic entry_t round_sat(input sum_t v);
        sum_t r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 64'sd32767)
            return 16'sh7FFF;
        if (r < -64'sd32768)
            return 16'sh8000;
        return r[ENTRY_W-1:0];
    endfunction

endpackage

// ===== src/erm_if.sv =====
interface erm_in_if;
    logic                  valid;
    logic                  ready;
    logic signed [15:0]    angle_x;
    logic signed [15:0]    angle_y;
    logic signed [15:0]    angle_z;

    modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface erm_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [15:0]    m00;
    logic signed [15:0]    m01;
    logic signed [15:0]    m02;
    logic signed [15:0]    m10;
    logic signed [15:0]    m11;
    logic signed [15:0]    m12;
    logic signed [15:0]    m20;
    logic signed [15:0]    m21;
    logic signed [15:0]    m22;

    modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                    output m12, output m20, output m21, output m22, input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                    input m12, input m20, input m21, input m22, output ready);
endinterface

// ===== src/erm_cordic.sv =====
module erm_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [erm_pkg::ANGLE_W-1:0]  angle,
    output erm_pkg::trig_t                      sin_q20,
    output erm_pkg::trig_t                      cos_q20
);
    import erm_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic signed [RED_W-1:0] z1_reg;
    logic signed [RED_W-1:0] z1_next;
    logic signed [RED_W-1:0] zf;

    logic signed [CW-1:0] x_reg [1:N];
    logic signed [CW-1:0] y_reg [1:N];
    logic signed [CW-1:0] z_reg [0:N];
    logic                 neg_reg [0:N];
    logic signed [CW-1:0] x_s [0:N];
    logic signed [CW-1:0] y_s [0:N];
    trig_t                sin_reg;
    trig_t                cos_reg;

    logic signed [CW-1:0] xo;
    logic signed [CW-1:0] yo;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;

    // reduce to (-pi, pi]
    always_comb
    begin
        z1_next = RED_W'(angle) <<< 18;
        if (z1_next > PI_Q30)
            z1_next = z1_next - TWO_PI_Q30;
        else if (z1_next < -PI_Q30)
            z1_next = z1_next + TWO_PI_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg <= z1_next;
        end
    end

    // fold into [-pi/2, pi/2], negate both outputs at the end
    always_comb
    begin
        zf = z1_reg;
        if (z1_reg > HALF_PI_Q30)
            zf = z1_reg - PI_Q30;
        else if (z1_reg < -HALF_PI_Q30)
            zf = z1_reg + PI_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= zf[CW-1:0];
            neg_reg[0] <= (z1_reg > HALF_PI_Q30) || (z1_reg < -HALF_PI_Q30);
        end
    end

    assign x_s[0] = GAIN_Q30;
    assign y_s[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        if (i > 0)
        begin : g_tap
            assign x_s[i] = x_reg[i];
            assign y_s[i] = y_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_s[i] - (y_s[i] >>> i);
                    y_reg[i+1] <= y_s[i] + (x_s[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_s[i] + (y_s[i] >>> i);
                    y_reg[i+1] <= y_s[i] - (x_s[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign x_s[N] = x_reg[N];
    assign y_s[N] = y_reg[N];

    always_comb
    begin
        xo = neg_reg[N] ? -x_s[N] : x_s[N];
        yo = neg_reg[N] ? -y_s[N] : y_s[N];
        xr = (xo + 33'sd512) >>> 10;
        yr = (yo + 33'sd512) >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= xr[TRIG_W-1:0];
            sin_reg <= yr[TRIG_W-1:0];
        end
    end

    assign sin_q20 = sin_reg;
    assign cos_q20 = cos_reg;

endmodule

// ===== src/euler_rotation_matrix.sv =====
// Euler-angle rotation matrix, M = Rz * Rx * Ry in row-vector form.
// in_ch carries angle_x, angle_y, angle_z (signed Q4.12 radians); out_ch
// carries the 3x3 entries m00..m22 (signed Q2.14, saturated). Both are
// valid/ready channels; a transfer happens when valid and ready are high.
// Sine and cosine come from one CORDIC per axis, one rotation per stage
// (CORDIC_STAGES = 14), then four stages form and round the products.
// Throughput is one item per cycle unless the pipeline stalls; up to 21 items may be in flight.
// When the receiver holds ready low with a result waiting, the whole
// pipeline stalls and in_ch.ready drops; nothing is lost or repeated.
// While the last stage is empty the pipeline advances even with ready low.
// Reset clears the valid bits only; the data registers are not reset.
module euler_rotation_matrix (
    input  logic         clk,
    input  logic         rst_n,
    erm_in_if.sink       in_ch,
    erm_out_if.source    out_ch
);
    import erm_pkg::*;

    localparam int L = LATENCY;

    logic [L-1:0] vld_reg;
    logic         en;

    trig_t sx, cx, sy, cy, sz, cz;

    // multiply stage 1
    prod_t czcy_reg, szcx_reg, czsy_reg, szcy_reg, czcx_reg;
    prod_t szsy_reg, cxsy_reg, cxcy_reg, sxsy_reg, sxcy_reg;
    trig_t sz1_reg, cz1_reg, sx1_reg;

    // multiply stage 2: triple products as high and low partials
    prod_t                      czcy2_reg, szcx2_reg, czsy2_reg, szcy2_reg, czcx2_reg;
    prod_t                      szsy2_reg, cxsy2_reg, cxcy2_reg;
    trig_t                      sx2_reg;
    prod_t                      a_hi_reg, b_hi_reg, c_hi_reg, d_hi_reg;
    logic signed [PROD_W:0]     a_lo_reg, b_lo_reg, c_lo_reg, d_lo_reg;

    // sum stage
    sum_t e00_reg, e01_reg, e02_reg, e10_reg, e11_reg, e12_reg, e20_reg, e21_reg, e22_reg;
    sum_t t_a, t_b, t_c, t_d;

    entry_t m00_reg, m01_reg, m02_reg, m10_reg, m11_reg, m12_reg, m20_reg, m21_reg, m22_reg;

    // a stage advances unless the last one holds a result not yet taken
    assign en          = !vld_reg[L-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[L-2:0], in_ch.valid};
    end

    erm_cordic u_cordic_x (.clk(clk), .en(en), .angle(in_ch.angle_x), .sin_q20(sx), .cos_q20(cx));
    erm_cordic u_cordic_y (.clk(clk), .en(en), .angle(in_ch.angle_y), .sin_q20(sy), .cos_q20(cy));
    erm_cordic u_cordic_z (.clk(clk), .en(en), .angle(in_ch.angle_z), .sin_q20(sz), .cos_q20(cz));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czcy_reg <= cz * cy;
            szcx_reg <= sz * cx;
            czsy_reg <= cz * sy;
            szcy_reg <= sz * cy;
            czcx_reg <= cz * cx;
            szsy_reg <= sz * sy;
            cxsy_reg <= cx * sy;
            cxcy_reg <= cx * cy;
            sxsy_reg <= sx * sy;
            sxcy_reg <= sx * cy;
            sz1_reg  <= sz;
            cz1_reg  <= cz;
            sx1_reg  <= sx;
        end
    end

    // split the 44-bit pair products sx*sy and sx*cy into a signed high half and an unsigned low half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czcy2_reg <= czcy_reg;
            szcx2_reg <= szcx_reg;
            czsy2_reg <= czsy_reg;
            szcy2_reg <= szcy_reg;
            czcx2_reg <= czcx_reg;
            szsy2_reg <= szsy_reg;
            cxsy2_reg <= cxsy_reg;
            cxcy2_reg <= cxcy_reg;
            sx2_reg   <= sx1_reg;
            a_hi_reg  <= sz1_reg * $signed(sxsy_reg[PROD_W-1:TRIG_W]);
            a_lo_reg  <= sz1_reg * $signed({1'b0, sxsy_reg[TRIG_W-1:0]});
            b_hi_reg  <= sz1_reg * $signed(sxcy_reg[PROD_W-1:TRIG_W]);
            b_lo_reg  <= sz1_reg * $signed({1'b0, sxcy_reg[TRIG_W-1:0]});
            c_hi_reg  <= cz1_reg * $signed(sxsy_reg[PROD_W-1:TRIG_W]);
            c_lo_reg  <= cz1_reg * $signed({1'b0, sxsy_reg[TRIG_W-1:0]});
            d_hi_reg  <= cz1_reg * $signed(sxcy_reg[PROD_W-1:TRIG_W]);
            d_lo_reg  <= cz1_reg * $signed({1'b0, sxcy_reg[TRIG_W-1:0]});
        end
    end

    always_comb
    begin
        t_a = (SUM_W'(a_hi_reg) <<< TRIG_W) + SUM_W'(a_lo_reg);
        t_b = (SUM_W'(b_hi_reg) <<< TRIG_W) + SUM_W'(b_lo_reg);
        t_c = (SUM_W'(c_hi_reg) <<< TRIG_W) + SUM_W'(c_lo_reg);
        t_d = (SUM_W'(d_hi_reg) <<< TRIG_W) + SUM_W'(d_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e00_reg <= (SUM_W'(czcy2_reg) <<< 20) + t_a;
            e01_reg <= SUM_W'(szcx2_reg) <<< 20;
            e02_reg <= t_b - (SUM_W'(czsy2_reg) <<< 20);
            e10_reg <= t_c - (SUM_W'(szcy2_reg) <<< 20);
            e11_reg <= SUM_W'(czcx2_reg) <<< 20;
            e12_reg <= (SUM_W'(szsy2_reg) <<< 20) + t_d;
            e20_reg <= SUM_W'(cxsy2_reg) <<< 20;
            e21_reg <= -(SUM_W'(sx2_reg) <<< 40);
            e22_reg <= SUM_W'(cxcy2_reg) <<< 20;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg <= round_sat(e00_reg);
            m01_reg <= round_sat(e01_reg);
            m02_reg <= round_sat(e02_reg);
            m10_reg <= round_sat(e10_reg);
            m11_reg <= round_sat(e11_reg);
            m12_reg <= round_sat(e12_reg);
            m20_reg <= round_sat(e20_reg);
            m21_reg <= round_sat(e21_reg);
            m22_reg <= round_sat(e22_reg);
        end
    end

    assign out_ch.valid = vld_reg[L-1];
    assign out_ch.m00   = m00_reg;
    assign out_ch.m01   = m01_reg;
    assign out_ch.m02   = m02_reg;
    assign out_ch.m10   = m10_reg;
    assign out_ch.m11   = m11_reg;
    assign out_ch.m12   = m12_reg;
    assign out_ch.m20   = m20_reg;
    assign out_ch.m21   = m21_reg;
    assign out_ch.m22   = m22_reg;

endmodule

// ===== verif/erm_checker.sv =====
`timescale 1ns / 100ps

module erm_checker (
    input  logic   clk,
    input  logic   rst_n,
    erm_in_if      in_ch,
    erm_out_if     out_ch,
    output int     fail_count,
    output int     pending,
    output int     matrices_seen
);
    import erm_pkg::*;

    typedef struct packed {
        logic signed [15:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    } matrix_t;

    localparam longint PI_V      = 64'd3373259426;
    localparam longint TWO_PI_V  = 64'd6746518852;
    localparam longint HALF_PI_V = 64'd1686629713;
    localparam longint GAIN_V    = 64'd652032874;

    matrix_t expected_q[$];

    function automatic longint arctan_q30(input int idx);
        longint tbl [24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[idx];
    endfunction

    // sine and cosine in Q20 of a Q4.12 angle
    task automatic sincos(input logic signed [15:0] ang, output longint s, output longint c);
        longint z, x, y, t;
        bit flip;
        int stages;
        z = longint'(ang) * 262144;
        x = GAIN_V;
        y = 0;
        flip = 0;
        stages = (TRIG_STAGES > 24) ? 24 : TRIG_STAGES;
        if (z > PI_V)
            z -= TWO_PI_V;
        else if (z < -PI_V)
            z += TWO_PI_V;
        if (z > HALF_PI_V)
        begin
            z -= PI_V;
            flip = 1;
        end
        else if (z < -HALF_PI_V)
        begin
            z += PI_V;
            flip = 1;
        end
        for (int i = 0; i < stages; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_q30(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_q30(i);
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
    endtask

    function automatic logic signed [15:0] q60_to_q14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic predict_matrix(input logic signed [15:0] ax, ay, az);
        longint sx, cx, sy, cy, sz, cz, one;
        matrix_t m;
        one = 64'sd1 <<< 20;
        sincos(ax, sx, cx);
        sincos(ay, sy, cy);
        sincos(az, sz, cz);
        m.e00 = q60_to_q14(cz * cy * one + sz * sx * sy);
        m.e01 = q60_to_q14(sz * cx * one);
        m.e02 = q60_to_q14(-(cz * sy * one) + sz * sx * cy);
        m.e10 = q60_to_q14(-(sz * cy * one) + cz * sx * sy);
        m.e11 = q60_to_q14(cz * cx * one);
        m.e12 = q60_to_q14(sz * sy * one + cz * sx * cy);
        m.e20 = q60_to_q14(cx * sy * one);
        m.e21 = q60_to_q14(-(sx * one * one));
        m.e22 = q60_to_q14(cx * cy * one);
        expected_q.push_back(m);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic compare_entry(input string nm, input logic signed [15:0] got, want);
        if (got !== want)
            report(nm, got, want);
    endtask

    initial
    begin
        fail_count = 0;
        matrices_seen = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        matrix_t w;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                predict_matrix(in_ch.angle_x, in_ch.angle_y, in_ch.angle_z);
            if (out_ch.valid && out_ch.ready)
            begin
                matrices_seen++;
                if (expected_q.size() == 0)
                    report("unexpected matrix", 0, 0);
                else
                begin
                    w = expected_q.pop_front();
                    compare_entry("m00", out_ch.m00, w.e00);
                    compare_entry("m01", out_ch.m01, w.e01);
                    compare_entry("m02", out_ch.m02, w.e02);
                    compare_entry("m10", out_ch.m10, w.e10);
                    compare_entry("m11", out_ch.m11, w.e11);
                    compare_entry("m12", out_ch.m12, w.e12);
                    compare_entry("m20", out_ch.m20, w.e20);
                    compare_entry("m21", out_ch.m21, w.e21);
                    compare_entry("m22", out_ch.m22, w.e22);
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import erm_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   fail_count, pending, matrices_seen;
    int   cycle_count;
    int   send_idle_pct, stall_pct;
    bit   long_hold;
    int   angles_sent;

    erm_in_if  in_ch ();
    erm_out_if out_ch ();

    euler_rotation_matrix dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    erm_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                     .fail_count(fail_count), .pending(pending),
                     .matrices_seen(matrices_seen));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.angle_x = '0;
        in_ch.angle_y = '0;
        in_ch.angle_z = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        long_hold = 0;
        angles_sent = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("euler_rotation_matrix regression: fail");
            $finish;
        end
    end

    // receiver: random stall, or hold off entirely during the long hold
    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end

    task automatic send_angles(input logic signed [15:0] ax, ay, az);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.angle_x <= ax;
        in_ch.angle_y <= ay;
        in_ch.angle_z <= az;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        angles_sent++;
    endtask

    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] specials [10] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
            16'shFFFF, 16'sh3244, 16'shCDBC, 16'sh1922, 16'shE6DE, 16'sh6488};
        case ($urandom_range(3))
            0:       return specials[$urandom_range(9)];
            1:       return 16'($urandom_range(32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] ext [10];
        int hold_cycles;
        ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
            16'shFFFF, 16'sh3244, 16'shCDBC, 16'sh1922, 16'shE6DE, 16'sh6488};
        @(posedge rst_n);
        @(negedge clk);
        // directed: extremes, multiples of pi and pi/2, each axis alone
        for (int i = 0; i < 10; i++)
            send_angles(ext[i], ext[(i + 3) % 10], ext[(i + 7) % 10]);
        send_angles(16'sh1922, 16'sh0000, 16'sh0000);
        send_angles(16'sh0000, 16'sh1922, 16'sh0000);
        send_angles(16'sh0000, 16'sh0000, 16'sh1922);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 70 : 27) : 0;
            stall_pct     = (phase == 2 || phase == 3) ? ((phase == 2) ? 70 : 27) : 0;
            if (phase == 0)
            begin
                // hold the output off while the sender keeps offering transfers
                fork
                    begin
                        long_hold = 1;
                        hold_cycles = 0;
                        while (hold_cycles < 80)
                        begin
                            @(posedge clk);
                            hold_cycles++;
                        end
                        long_hold = 0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        in_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d angle triples, %0d matrices checked, under four idle/stall mixes",
                 angles_sent, matrices_seen);
        if (fail_count == 0)
            $display("euler_rotation_matrix regression: pass");
        else
            $display("euler_rotation_matrix regression: fail");
        $finish;
    end
endmodule

// ===== euler_rotation_matrix.f =====
src/erm_pkg.sv
src/erm_if.sv
src/erm_cordic.sv
src/euler_rotation_matrix.sv
verif/erm_checker.sv
verif/tb.sv
